@@ hdl/gf2n_block_doubler_core_macros.svh @@
// Assertion macros shared by the block doubler RTL.
`ifndef GF2N_BLOCK_DOUBLER_CORE_MACROS_SVH
`define GF2N_BLOCK_DOUBLER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Property checked on every rising edge outside reset.
`define GBD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition that must never be seen outside reset.
`define GBD_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define GBD_ASSERT(lbl, prop, msg)
`define GBD_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

@@ hdl/gf2nbd_pkg.sv @@
// Types, constants and helper functions of the block doubler.
package gf2nbd_pkg;

    localparam int LIMB_W     = 64;
    localparam int MAX_LIMBS  = 16;
    localparam int IDX_W      = $clog2(MAX_LIMBS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int SIZE_W     = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENDIAN = 2'd1;

    // Input operation codes
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_DOUBLE = 1'b1;

    // Block size codes
    localparam logic [SIZE_W-1:0] SZ_64   = 3'd0;
    localparam logic [SIZE_W-1:0] SZ_128  = 3'd1;
    localparam logic [SIZE_W-1:0] SZ_192  = 3'd2;
    localparam logic [SIZE_W-1:0] SZ_256  = 3'd3;
    localparam logic [SIZE_W-1:0] SZ_512  = 3'd4;
    localparam logic [SIZE_W-1:0] SZ_1024 = 3'd5;

    // Control handed from the sequencer to the limb ALU
    typedef struct packed {
        logic                  little_endian;
        logic                  first_limb;   // limb 0 of the emitted block
        logic                  final_limb;   // last limb of the emitted block
        logic                  carry;        // top bit of the block was set
        logic [SIZE_W-1:0]     size_code;
    } alu_ctl_t;

    // Limbs in the block for a size code; unused codes act as 1024 bits
    function automatic logic [CNT_W-1:0] limb_count(input logic [SIZE_W-1:0] sz);
        logic [CNT_W-1:0] n;
        case (sz)
            SZ_64:   n = CNT_W'(1);
            SZ_128:  n = CNT_W'(2);
            SZ_192:  n = CNT_W'(3);
            SZ_256:  n = CNT_W'(4);
            SZ_512:  n = CNT_W'(8);
            default: n = CNT_W'(MAX_LIMBS);
        endcase
        return n;
    endfunction

    // Reduction constant of the minimum-weight polynomial per size
    function automatic logic [LIMB_W-1:0] red_poly(input logic [SIZE_W-1:0] sz);
        logic [LIMB_W-1:0] p;
        case (sz)
            SZ_64:          p = LIMB_W'(20'h0001B);
            SZ_128, SZ_192: p = LIMB_W'(20'h00087);
            SZ_256:         p = LIMB_W'(20'h00425);
            SZ_512:         p = LIMB_W'(20'h00125);
            default:        p = LIMB_W'(20'h80043);
        endcase
        return p;
    endfunction

    // Byte reversal of one limb
    function automatic logic [LIMB_W-1:0] swap_bytes(input logic [LIMB_W-1:0] v);
        logic [LIMB_W-1:0] r;
        for (int k = 0; k < LIMB_W / 8; k++) begin
            r[LIMB_W-1-8*k -: 8] = v[8*k +: 8];
        end
        return r;
    endfunction

endpackage

@@ hdl/gf2nbd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module gf2nbd_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, data held while no read is issued
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ hdl/gf2nbd_limb_alu.sv @@
// One limb of the multiply-by-x step, for either byte and limb order.
module gf2nbd_limb_alu
    import gf2nbd_pkg::*;
(
    input  alu_ctl_t          ctl,
    input  logic [LIMB_W-1:0] cur,   // limb just read from the store
    input  logic [LIMB_W-1:0] prev,  // limb read one step earlier
    output logic [LIMB_W-1:0] res    // doubled limb, memory byte order
);

    logic [LIMB_W-1:0] poly;
    logic [LIMB_W-1:0] cur_w;
    logic [LIMB_W-1:0] prev_w;
    logic [LIMB_W-1:0] be_res;
    logic [LIMB_W-1:0] le_res;

    assign poly   = ctl.carry ? red_poly(ctl.size_code) : '0;
    assign cur_w  = swap_bytes(cur);
    assign prev_w = swap_bytes(prev);

    // Big-endian: output limb is prev, low bit fed from the next limb's top bit
    assign be_res = ctl.final_limb ? ({prev[LIMB_W-2:0], 1'b0} ^ poly)
                                   : {prev[LIMB_W-2:0], cur[LIMB_W-1]};

    // Little-endian: output limb is cur, low bit fed from the lower limb's top bit
    assign le_res = ctl.first_limb
                  ? swap_bytes({cur_w[LIMB_W-2:0], 1'b0} ^ poly)
                  : swap_bytes({cur_w[LIMB_W-2:0], prev_w[LIMB_W-1]});

    assign res = ctl.little_endian ? le_res : be_res;

endmodule

@@ hdl/gf2n_block_doubler_core.sv @@
// Block doubler: multiply a stored GF(2^n) block by x, read-modify-write over a limb RAM.
// Load transaction: one per cycle while idle, written to the limb RAM at the accepting edge.
// Double transaction: limbs out one per cycle while the output is not stalled
// (n+1 RAM reads for n limbs); input ready again once the last limb is written back.
// The single limb RAM read port sets the rate; output stalls hold the read sequence.
// Reset (rst_n low, asynchronous): size 128 bits, big-endian, load index 0, no output.
`include "gf2n_block_doubler_core_macros.svh"

module gf2n_block_doubler_core
    import gf2nbd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [LIMB_W-1:0]     s_axis_tdata,   // [63:0] data_in
    input  logic                  s_axis_tuser,   // [0] op
    // output stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [LIMB_W-1:0]     m_axis_tdata,   // [63:0] data_out
    output logic                  m_axis_tlast,
    // configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [SIZE_W-1:0] size_reg;
    logic              le_reg;
    logic [IDX_W-1:0]  load_idx_reg, load_idx_next;
    logic              busy_reg;
    logic [CNT_W-1:0]  iss_reg;
    logic [CNT_W-1:0]  cns_reg;
    logic              rd_vld_reg;
    logic              carry_reg;
    logic [LIMB_W-1:0] prev_reg;
    logic              out_vld_reg;
    logic [LIMB_W-1:0] out_data_reg;
    logic              out_last_reg;

    logic [CNT_W-1:0]  n_limbs;
    logic              in_acc, do_load, do_double;
    logic              consume, issue, do_out, final_step;
    logic [CNT_W-1:0]  rd_step_addr;
    logic [CNT_W-1:0]  wb_step_addr;
    logic [CNT_W-1:0]  load_inc;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [LIMB_W-1:0] wr_data;
    logic [LIMB_W-1:0] rd_data;
    logic [LIMB_W-1:0] alu_res;
    alu_ctl_t          alu_ctl;

    assign n_limbs = limb_count(size_reg);

    // Handshakes
    assign s_axis_tready = !busy_reg;
    assign cfg_ready     = 1'b1;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign do_load       = in_acc && (s_axis_tuser == OP_LOAD);
    assign do_double     = in_acc && (s_axis_tuser == OP_DOUBLE);

    // Read sequencing: step 0 fetches the carry limb, steps 1..n emit a limb each
    assign consume    = rd_vld_reg && (!out_vld_reg || m_axis_tready);
    assign issue      = busy_reg && (iss_reg <= n_limbs) && (!rd_vld_reg || consume);
    assign do_out     = consume && (cns_reg != '0);
    assign final_step = (cns_reg == n_limbs);

    // Little-endian reads top limb first, then 0..n-1; big-endian reads 0..n-1 then a spare
    always_comb
    begin
        if (le_reg)
        begin
            rd_step_addr = (iss_reg == '0) ? (n_limbs - CNT_W'(1)) : (iss_reg - CNT_W'(1));
        end
        else
        begin
            rd_step_addr = (iss_reg < n_limbs) ? iss_reg : '0;
        end
    end

    assign wb_step_addr = cns_reg - CNT_W'(1);

    // Limb ALU
    assign alu_ctl.little_endian = le_reg;
    assign alu_ctl.first_limb    = (cns_reg == CNT_W'(1));
    assign alu_ctl.final_limb    = final_step;
    assign alu_ctl.carry         = carry_reg;
    assign alu_ctl.size_code     = size_reg;

    gf2nbd_limb_alu u_alu (
        .ctl  (alu_ctl),
        .cur  (rd_data),
        .prev (prev_reg),
        .res  (alu_res)
    );

    // Store write port: loads when idle, write-back while doubling
    assign wr_en   = do_load || do_out;
    assign wr_addr = busy_reg ? wb_step_addr[IDX_W-1:0] : load_idx_reg;
    assign wr_data = busy_reg ? alu_res : s_axis_tdata;

    gf2nbd_ram #(
        .WIDTH (LIMB_W),
        .DEPTH (MAX_LIMBS)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (issue),
        .rd_addr (rd_step_addr[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    // Load index with wrap at the current limb count, cleared by a double
    assign load_inc = CNT_W'(load_idx_reg + IDX_W'(1));

    always_comb
    begin
        load_idx_next = load_idx_reg;
        if (do_double)
        begin
            load_idx_next = '0;
        end
        else if (do_load)
        begin
            load_idx_next = (load_inc >= n_limbs) ? '0 : load_inc[IDX_W-1:0];
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= SZ_128;
            le_reg   <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_SIZE:   size_reg <= cfg_data[SIZE_W-1:0];
                CFG_ENDIAN: le_reg   <= cfg_data[0];
                default:    ;
            endcase
        end
    end

    // Sequencer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_idx_reg <= '0;
            busy_reg     <= 1'b0;
            iss_reg      <= '0;
            cns_reg      <= '0;
            rd_vld_reg   <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            load_idx_reg <= load_idx_next;

            if (do_double)
            begin
                busy_reg <= 1'b1;
                iss_reg  <= '0;
                cns_reg  <= '0;
            end
            else
            begin
                if (consume && final_step)
                begin
                    busy_reg <= 1'b0;
                end
                if (issue)
                begin
                    iss_reg <= iss_reg + CNT_W'(1);
                end
                if (consume)
                begin
                    cns_reg <= cns_reg + CNT_W'(1);
                end
            end

            if (issue)
            begin
                rd_vld_reg <= 1'b1;
            end
            else if (consume)
            begin
                rd_vld_reg <= 1'b0;
            end

            if (do_out)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (consume)
        begin
            prev_reg <= rd_data;
            if (cns_reg == '0)
            begin
                carry_reg <= le_reg ? rd_data[7] : rd_data[LIMB_W-1];
            end
        end
        if (do_out)
        begin
            out_data_reg <= alu_res;
            out_last_reg <= final_step;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    // Checks
    `GBD_ASSERT_NEVER(a_consume_ahead, cns_reg > iss_reg, "consumed a read never issued")
    `GBD_ASSERT_NEVER(a_issue_bound, busy_reg && (iss_reg > n_limbs + CNT_W'(1)), "read overrun")
    `GBD_ASSERT(a_read_lands, issue |=> rd_vld_reg, "issued read produced no data")
    `GBD_ASSERT(a_end_last, $fell(busy_reg) |-> (out_vld_reg && out_last_reg), "block ended without last limb")

endmodule
